/* rtl/rhdu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhdu_pkg
// Shared types, codes and helper functions of the response body deframer.
// ----------------------------------------------------------------------------
package rhdu_pkg;

    typedef enum logic [3:0] {
        PH_VERSION, PH_STAT_LEAD, PH_STAT_DIGITS, PH_HEADERS,
        PH_CHUNK_SIZE, PH_CHUNK_EXT, PH_CHUNK_DATA, PH_CHUNK_TRAIL,
        PH_LENGTH_BODY, PH_CLOSE_BODY, PH_DONE, PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] body_byte;
        logic [9:0] http_status;
    } t_result;

    // One queue entry holds every result caused by one request.
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    localparam int MAX_W      = 40;
    localparam int WIN_LEN    = 18;
    localparam int QDEPTH     = 4;
    localparam logic [MAX_W-1:0] MAX_RESET = 40'd10485760;
    localparam logic [9:0] STATUS_MIN = 10'd100;
    localparam logic [9:0] STATUS_MAX = 10'd999;
    localparam logic [9:0] STATUS_SAT = 10'd1000;

    localparam logic [8*18-1:0] KW_ENC = "transfer-encoding:";
    localparam logic [8*15-1:0] KW_LEN = "content-length:";
    localparam logic [8*7-1:0]  KW_CHK = "chunked";
    localparam logic [8*7-1:0]  KW_VER = "HTTP/1.";

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_ONE   = 8'd49;
    localparam logic [7:0] CH_NINE  = 8'd57;

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Returns a valid flag above the four value bits.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] f;
        f = fold(c);
        if (is_dig(c)) begin
            hex_val = {1'b1, c[3:0]};
        end else if (f >= 8'd97 && f <= 8'd102) begin
            hex_val = {1'b1, 4'(f - 8'd87)};
        end else begin
            hex_val = 5'd0;
        end
    endfunction

endpackage

/* rtl/rhdu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhdu_front
// Parses one response byte per cycle in which a byte is taken and forms the results it causes.
// ----------------------------------------------------------------------------
module rhdu_front import rhdu_pkg::*; #(
    parameter int COUNT_WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [MAX_W-1:0] i_cfg_data,
    input  logic             i_take,
    input  logic [7:0]       i_data_byte,
    input  logic             i_closed,
    output logic             o_wr,
    output t_entry           o_entry
);

    localparam int VW = (COUNT_WIDTH > MAX_W) ? COUNT_WIDTH : MAX_W;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    logic [MAX_W-1:0]       r_max,  n_max;
    t_phase                 r_phase, n_phase;
    logic [7:0]             r_win [WIN_LEN];
    logic [7:0]             n_win [WIN_LEN];
    logic [3:0]             r_pos,  n_pos;
    logic [9:0]             r_stat, n_stat;
    logic [1:0]             r_tm,   n_tm;
    logic                   r_enc,  n_enc;
    logic                   r_lens, n_lens;
    logic                   r_chk,  n_chk;
    logic [2:0]             r_km,   n_km;
    logic [1:0]             r_lst,  n_lst;
    logic [COUNT_WIDTH-1:0] r_decl, n_decl;
    logic [COUNT_WIDTH-1:0] r_crem, n_crem;
    logic [COUNT_WIDTH-1:0] r_tot,  n_tot;

    logic [7:0]             b;
    logic                   enc_hit, len_hit;
    logic [COUNT_WIDTH+3:0] decl_x10;
    logic [4:0]             hx;
    logic [VW-1:0]          tot_v, max_v, crem_v, decl_v, inc_v;
    logic [COUNT_WIDTH-1:0] tot_inc, crem_dec;

    t_result res_err, res_done, res_byte;

    always_comb begin
        b = i_data_byte;
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            n_win[i] = r_win[i+1];
        end
        n_win[WIN_LEN-1] = b;
        enc_hit = 1'b1;
        for (int i = 0; i < 18; i++) begin
            if (fold(n_win[i]) != KW_ENC[8*(17-i) +: 8]) enc_hit = 1'b0;
        end
        len_hit = 1'b1;
        for (int i = 0; i < 15; i++) begin
            if (fold(n_win[WIN_LEN-15+i]) != KW_LEN[8*(14-i) +: 8]) len_hit = 1'b0;
        end
        decl_x10 = ({4'd0, r_decl} << 3) + ({4'd0, r_decl} << 1)
                 + (COUNT_WIDTH+4)'(b - CH_ZERO);
        hx       = hex_val(b);
        tot_v    = VW'(r_tot);
        max_v    = VW'(r_max);
        crem_v   = VW'(r_crem);
        decl_v   = VW'(r_decl);
        tot_inc  = (r_tot == CMAX) ? CMAX : r_tot + 1'b1;
        inc_v    = VW'(tot_inc);
        crem_dec = (r_crem != '0) ? r_crem - 1'b1 : r_crem;
        res_err  = '{kind: KIND_ERROR, body_byte: 8'd0, http_status: 10'd0};
        res_done = '{kind: KIND_DONE,  body_byte: 8'd0, http_status: r_stat};
        res_byte = '{kind: KIND_BYTE,  body_byte: b,    http_status: 10'd0};
    end

    always_comb begin
        n_max   = i_cfg_we ? i_cfg_data : r_max;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_stat  = r_stat;
        n_tm    = r_tm;
        n_enc   = r_enc;
        n_lens  = r_lens;
        n_chk   = r_chk;
        n_km    = r_km;
        n_lst   = r_lst;
        n_decl  = r_decl;
        n_crem  = r_crem;
        n_tot   = r_tot;
        o_wr    = 1'b0;
        o_entry = '{two: 1'b0, r0: res_err, r1: res_err};

        if (i_take && r_phase < PH_DONE) begin
            if (i_closed) begin
                o_wr = 1'b1;
                if (r_phase <= PH_HEADERS) begin
                    n_phase = PH_ERROR;
                end else begin
                    n_phase = PH_DONE;
                    o_entry.r0 = res_done;
                end
            end else if (r_phase <= PH_HEADERS) begin
                if (b == (r_tm[0] ? CH_LF : CH_CR) && r_tm == 2'd3) begin
                    // Blank line: decide how the body is framed.
                    if (r_stat < STATUS_MIN || r_stat > STATUS_MAX) begin
                        o_wr = 1'b1;
                        n_phase = PH_ERROR;
                    end else if (r_chk) begin
                        n_phase = PH_CHUNK_SIZE;
                        n_crem = '0;
                        n_tm = 2'd0;
                    end else if (r_lens) begin
                        if (r_lst == 2'd0 || r_lst == 2'd3) begin
                            o_wr = 1'b1;
                            n_phase = PH_ERROR;
                        end else if (r_decl == '0) begin
                            o_wr = 1'b1;
                            o_entry.r0 = res_done;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_LENGTH_BODY;
                        end
                    end else begin
                        n_phase = PH_CLOSE_BODY;
                    end
                end else begin
                    if (b == (r_tm[0] ? CH_LF : CH_CR)) n_tm = r_tm + 2'd1;
                    else n_tm = (b == CH_CR) ? 2'd1 : 2'd0;

                    case (r_phase)
                        PH_VERSION: begin
                            if (r_pos < 4'd7) begin
                                if (b != KW_VER[8*(6-32'(r_pos[2:0])) +: 8]) begin
                                    n_stat = 10'd0;
                                    n_phase = PH_HEADERS;
                                end
                            end else if (r_pos == 4'd7) begin
                                if (b != CH_ZERO && b != CH_ONE) begin
                                    n_stat = 10'd0;
                                    n_phase = PH_HEADERS;
                                end
                            end else begin
                                n_phase = PH_STAT_LEAD;
                            end
                        end
                        PH_STAT_LEAD: begin
                            if (is_dig(b)) begin
                                n_stat = 10'(b - CH_ZERO);
                                n_phase = PH_STAT_DIGITS;
                            end else if (b == CH_PLUS) begin
                                n_stat = 10'd0;
                                n_phase = PH_STAT_DIGITS;
                            end else if (!is_ws(b)) begin
                                n_stat = 10'd0;
                                n_phase = PH_HEADERS;
                            end
                        end
                        PH_STAT_DIGITS: begin
                            if (is_dig(b)) begin
                                n_stat = (r_stat >= STATUS_MIN) ? STATUS_SAT
                                       : 10'((r_stat << 3) + (r_stat << 1))
                                         + 10'(b - CH_ZERO);
                            end else begin
                                n_phase = PH_HEADERS;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (r_pos != 4'hF) n_pos = r_pos + 4'd1;

                    if (r_enc) begin
                        if (r_km < 3'd7) begin
                            if (r_km == 3'd0 && b == CH_SPACE) begin
                                n_km = r_km;
                            end else if (fold(b) == KW_CHK[8*(6-32'(r_km)) +: 8]) begin
                                n_km = r_km + 3'd1;
                                if (r_km == 3'd6) n_chk = 1'b1;
                            end else begin
                                n_km = 3'd7;
                            end
                        end
                    end else if (enc_hit) begin
                        n_enc = 1'b1;
                        n_km = 3'd0;
                    end

                    if (r_lens) begin
                        if (r_lst == 2'd0) begin
                            if (is_dig(b)) begin
                                n_decl = COUNT_WIDTH'(b - CH_ZERO);
                                n_lst = 2'd1;
                            end else if (!is_ws(b)) begin
                                n_lst = 2'd3;
                            end
                        end else if (r_lst == 2'd1) begin
                            if (is_dig(b)) begin
                                n_decl = (decl_x10 > (COUNT_WIDTH+4)'(CMAX)) ? CMAX
                                       : decl_x10[COUNT_WIDTH-1:0];
                            end else begin
                                n_lst = 2'd2;
                            end
                        end
                    end else if (len_hit) begin
                        n_lens = 1'b1;
                        n_lst = 2'd0;
                    end
                end
            end else begin
                case (r_phase)
                    PH_CHUNK_SIZE: begin
                        if (hx[4]) begin
                            n_crem = (r_crem > (CMAX >> 4)) ? CMAX
                                   : {r_crem[COUNT_WIDTH-5:0], hx[3:0]};
                        end else begin
                            n_phase = PH_CHUNK_EXT;
                            n_tm = (b == CH_CR) ? 2'd1 : 2'd0;
                        end
                    end
                    PH_CHUNK_EXT: begin
                        if (b == CH_LF && r_tm == 2'd1) begin
                            if (r_crem == '0) begin
                                o_wr = 1'b1;
                                o_entry.r0 = res_done;
                                n_phase = PH_DONE;
                            end else if (tot_v > max_v || crem_v > max_v - tot_v) begin
                                o_wr = 1'b1;
                                n_phase = PH_ERROR;
                            end else begin
                                n_phase = PH_CHUNK_DATA;
                            end
                        end else begin
                            n_tm = (b == CH_CR) ? 2'd1 : 2'd0;
                        end
                    end
                    PH_CHUNK_DATA: begin
                        o_wr = 1'b1;
                        o_entry.r0 = res_byte;
                        n_tot = tot_inc;
                        n_crem = crem_dec;
                        if (crem_dec == '0) begin
                            n_phase = PH_CHUNK_TRAIL;
                            n_tm = 2'd0;
                        end
                    end
                    PH_CHUNK_TRAIL: begin
                        if (r_tm >= 2'd1) begin
                            n_phase = PH_CHUNK_SIZE;
                            n_crem = '0;
                            n_tm = 2'd0;
                        end else begin
                            n_tm = r_tm + 2'd1;
                        end
                    end
                    PH_LENGTH_BODY, PH_CLOSE_BODY: begin
                        o_wr = 1'b1;
                        if (tot_v >= max_v) begin
                            n_phase = PH_ERROR;
                        end else begin
                            o_entry.r0 = res_byte;
                            n_tot = tot_inc;
                            if (r_phase == PH_LENGTH_BODY && inc_v >= decl_v) begin
                                o_entry.two = 1'b1;
                                o_entry.r1 = res_done;
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MAX_RESET;
            r_phase <= PH_VERSION;
            for (int i = 0; i < WIN_LEN; i++) r_win[i] <= 8'd0;
            r_pos   <= 4'd0;
            r_stat  <= 10'd0;
            r_tm    <= 2'd0;
            r_enc   <= 1'b0;
            r_lens  <= 1'b0;
            r_chk   <= 1'b0;
            r_km    <= 3'd0;
            r_lst   <= 2'd0;
            r_decl  <= '0;
            r_crem  <= '0;
            r_tot   <= '0;
        end else begin
            r_max   <= n_max;
            r_phase <= n_phase;
            if (i_take && !i_closed && r_phase <= PH_HEADERS) begin
                for (int i = 0; i < WIN_LEN; i++) r_win[i] <= n_win[i];
            end
            r_pos   <= n_pos;
            r_stat  <= n_stat;
            r_tm    <= n_tm;
            r_enc   <= n_enc;
            r_lens  <= n_lens;
            r_chk   <= n_chk;
            r_km    <= n_km;
            r_lst   <= n_lst;
            r_decl  <= n_decl;
            r_crem  <= n_crem;
            r_tot   <= n_tot;
        end
    end

endmodule

/* rtl/rhdu_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhdu_queue
// Short register queue of result entries between the parser and the output.
// ----------------------------------------------------------------------------
module rhdu_queue import rhdu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_entry,
    input  logic   i_rd,
    output t_entry o_head,
    output logic   o_full,
    output logic   o_empty
);

    localparam int AW = $clog2(QDEPTH);

    t_entry        r_mem [QDEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [AW:0]   r_cnt, n_cnt;

    always_comb begin
        o_full  = (r_cnt == (AW+1)'(QDEPTH));
        o_empty = (r_cnt == '0);
        o_head  = r_mem[r_rp];
        n_wp    = i_wr ? r_wp + 1'b1 : r_wp;
        n_rp    = i_rd ? r_rp + 1'b1 : r_rp;
        n_cnt   = r_cnt + (AW+1)'(i_wr) - (AW+1)'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty) else $error("queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

/* rtl/rhdu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhdu_back
// Splits each queue entry into its one or two results and hands them out.
// ----------------------------------------------------------------------------
module rhdu_back import rhdu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  logic       i_q_empty,
    input  logic       i_pop,
    output logic       o_q_rd,
    output logic       o_empty,
    output logic [1:0] o_kind,
    output logic [7:0] o_body_byte,
    output logic [9:0] o_http_status,
    output logic       o_last
);

    logic    r_sel, n_sel;
    t_result cur;

    always_comb begin
        cur           = r_sel ? i_head.r1 : i_head.r0;
        o_empty       = i_q_empty;
        o_kind        = cur.kind;
        o_body_byte   = cur.body_byte;
        o_http_status = cur.http_status;
        o_last        = r_sel || !i_head.two;
        o_q_rd        = i_pop && !i_q_empty && o_last;
        n_sel         = r_sel;
        if (i_pop && !i_q_empty) n_sel = !o_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else begin
            r_sel <= n_sel;
        end
    end

endmodule

/* rtl/http_response_body_deframer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_body_deframer_unit
// HTTP/1.x response deframer with chunked transfer decoding.
// ----------------------------------------------------------------------------
// Input queue side: a request carries one response byte or a closed mark and
// is taken when push is high and full is low. One request is taken every
// cycle while the internal result queue has room.
// Result queue side: while empty is low the oldest result is on the o_ ports;
// pop takes it. A taken request's results are registered in the queue first.
// Most requests give zero or one result; the final byte of a declared length
// gives two (the byte, then completion), which take two pops.
// The parser handles one byte per cycle; the four-entry queue between it and
// the output lets the receiver stall without blocking the sender until the
// queue fills, and then full holds the sender.
// Reset clears the parser, the queue and sets the body limit to 10 MiB.
// i_cfg_we writes the body limit when high; use only while idle, not checked.
// After completion or error all requests are taken and dropped until reset.
// ----------------------------------------------------------------------------
module http_response_body_deframer_unit import rhdu_pkg::*; #(
    parameter int COUNT_WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [MAX_W-1:0] i_cfg_data,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_closed,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_body_byte,
    output logic [9:0]       o_http_status,
    output logic             o_last
);

    logic   take, wr, q_rd, q_empty;
    t_entry entry, head;

    assign take = push && !full;

    rhdu_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_take(take), .i_data_byte, .i_closed,
        .o_wr(wr), .o_entry(entry)
    );

    rhdu_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(wr), .i_entry(entry), .i_rd(q_rd),
        .o_head(head), .o_full(full), .o_empty(q_empty)
    );

    rhdu_back u_back (
        .i_clk, .i_rst_n, .i_head(head), .i_q_empty(q_empty), .i_pop(pop),
        .o_q_rd(q_rd), .o_empty(empty), .o_kind, .o_body_byte,
        .o_http_status, .o_last
    );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives one HTTP/1.1 response with a chunked body into the deframer, one
// request per byte, and checks every decoded byte and the final error against
// a cycle-free model of the parser. The body limit is rewritten between
// phases; the last setting forces an error at the next chunk size line.
// ----------------------------------------------------------------------------
module tb_top;
    import rhdu_pkg::*;

    localparam logic [63:0] CNT_ALL = 64'hFF_FFFF_FFFF;

    typedef struct {
        logic [7:0] data;
        logic       closed;
    } t_request;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] body_byte;
        logic [9:0] http_status;
        logic       last;
    } t_expected;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [MAX_W-1:0] i_cfg_data;
    logic             push;
    logic             full;
    logic [7:0]       i_data_byte;
    logic             i_closed;
    logic             empty;
    logic             pop;
    logic [1:0]       o_kind;
    logic [7:0]       o_body_byte;
    logic [9:0]       o_http_status;
    logic             o_last;

    http_response_body_deframer_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .i_closed     (i_closed),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_body_byte  (o_body_byte),
        .o_http_status(o_http_status),
        .o_last       (o_last)
    );

    t_request  pending_bytes[$];
    t_expected expected_results[$];
    int        mismatches;
    int        send_idle;
    int        recv_idle;
    int        taken_count;
    int        stall_left;
    bit        stall_done;

    // Parser model state.
    t_phase      ph;
    logic [7:0]  win[WIN_LEN];
    int          hdr_pos;
    int          status_val;
    int          term_cnt;
    bit          enc_seen, len_seen, chunked;
    int          kw_idx;
    int          len_stage;
    logic [63:0] decl_len, chunk_left, body_count, body_limit;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit white_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit window_ends_with(input string kw);
        int n;
        n = kw.len();
        for (int i = 0; i < n; i++) begin
            if (lower_case(win[WIN_LEN - n + i]) != kw[i]) return 0;
        end
        return 1;
    endfunction

    task automatic add_result(input t_kind k, input logic [7:0] b, input int st);
        t_expected e;
        e.kind = k;
        e.body_byte = b;
        e.http_status = st[9:0];
        e.last = 1'b0;
        expected_results.push_back(e);
    endtask

    task automatic parse_error();
        ph = PH_ERROR;
        add_result(KIND_ERROR, 8'd0, 0);
    endtask

    task automatic parse_done();
        ph = PH_DONE;
        add_result(KIND_DONE, 8'd0, status_val);
    endtask

    task automatic headers_finished();
        if (status_val < 100 || status_val > 999) begin
            parse_error();
        end else if (chunked) begin
            ph = PH_CHUNK_SIZE;
            chunk_left = 0;
            term_cnt = 0;
        end else if (len_seen) begin
            if (len_stage == 0 || len_stage == 3) parse_error();
            else if (decl_len == 0) parse_done();
            else ph = PH_LENGTH_BODY;
        end else begin
            ph = PH_CLOSE_BODY;
        end
    endtask

    task automatic header_step(input logic [7:0] b);
        string      ver;
        string      chk;
        int         tm;
        logic [7:0] want;
        logic [63:0] d;
        ver = "HTTP/1.";
        chk = "chunked";
        for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
        win[WIN_LEN - 1] = b;
        tm = term_cnt & 3;
        want = (tm[0]) ? 8'd10 : 8'd13;
        if (b == want) begin
            if (tm == 3) begin
                headers_finished();
                return;
            end
            term_cnt = tm + 1;
        end else begin
            term_cnt = (b == 8'd13) ? 1 : 0;
        end

        if (ph == PH_VERSION) begin
            if (hdr_pos < 7) begin
                if (b != ver[hdr_pos]) begin status_val = 0; ph = PH_HEADERS; end
            end else if (hdr_pos == 7) begin
                if (b != "0" && b != "1") begin status_val = 0; ph = PH_HEADERS; end
            end else begin
                ph = PH_STAT_LEAD;
            end
        end else if (ph == PH_STAT_LEAD) begin
            if (decimal(b)) begin
                status_val = b - "0";
                ph = PH_STAT_DIGITS;
            end else if (b == "+") begin
                status_val = 0;
                ph = PH_STAT_DIGITS;
            end else if (!white_space(b)) begin
                status_val = 0;
                ph = PH_HEADERS;
            end
        end else if (ph == PH_STAT_DIGITS) begin
            if (decimal(b))
                status_val = (status_val >= 100) ? 1000
                             : status_val * 10 + (b - "0");
            else ph = PH_HEADERS;
        end
        if (hdr_pos < 16'hFFFF) hdr_pos++;

        if (enc_seen) begin
            if (kw_idx < 7) begin
                if (kw_idx == 0 && b == " ") begin
                    // Spaces ahead of the value are skipped.
                end else if (lower_case(b) == chk[kw_idx]) begin
                    kw_idx++;
                    if (kw_idx == 7) chunked = 1;
                end else begin
                    kw_idx = 7;
                end
            end
        end else if (window_ends_with("transfer-encoding:")) begin
            enc_seen = 1;
            kw_idx = 0;
        end

        if (len_seen) begin
            if (len_stage == 0) begin
                if (decimal(b)) begin decl_len = b - "0"; len_stage = 1; end
                else if (!white_space(b)) len_stage = 3;
            end else if (len_stage == 1) begin
                if (decimal(b)) begin
                    d = b - "0";
                    decl_len = (decl_len > (CNT_ALL - d) / 10) ? CNT_ALL
                               : decl_len * 10 + d;
                end else begin
                    len_stage = 2;
                end
            end
        end else if (window_ends_with("content-length:")) begin
            len_seen = 1;
            len_stage = 0;
        end
    endtask

    task automatic body_step(input logic [7:0] b);
        logic [7:0] f;
        int         h;
        f = lower_case(b);
        h = decimal(b) ? b - "0" : (f >= "a" && f <= "f") ? f - "a" + 10 : -1;
        case (ph)
            PH_CHUNK_SIZE: begin
                if (h >= 0) begin
                    chunk_left = (chunk_left > (CNT_ALL >> 4)) ? CNT_ALL
                                 : (chunk_left << 4) | 64'(h);
                end else begin
                    ph = PH_CHUNK_EXT;
                    term_cnt = (b == 8'd13) ? 1 : 0;
                end
            end
            PH_CHUNK_EXT: begin
                if (b == 8'd10 && term_cnt == 1) begin
                    if (chunk_left == 0) parse_done();
                    else if (body_count > body_limit
                             || chunk_left > body_limit - body_count) parse_error();
                    else ph = PH_CHUNK_DATA;
                end else begin
                    term_cnt = (b == 8'd13) ? 1 : 0;
                end
            end
            PH_CHUNK_DATA: begin
                add_result(KIND_BYTE, b, 0);
                if (body_count < CNT_ALL) body_count++;
                if (chunk_left > 0) chunk_left--;
                if (chunk_left == 0) begin
                    ph = PH_CHUNK_TRAIL;
                    term_cnt = 0;
                end
            end
            PH_CHUNK_TRAIL: begin
                term_cnt++;
                if (term_cnt >= 2) begin
                    ph = PH_CHUNK_SIZE;
                    chunk_left = 0;
                    term_cnt = 0;
                end
            end
            PH_LENGTH_BODY, PH_CLOSE_BODY: begin
                if (body_count >= body_limit) begin
                    parse_error();
                end else begin
                    add_result(KIND_BYTE, b, 0);
                    if (body_count < CNT_ALL) body_count++;
                    if (ph == PH_LENGTH_BODY && body_count >= decl_len) parse_done();
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_request(input logic [7:0] b, input logic c);
        int before_n;
        before_n = expected_results.size();
        if (ph == PH_DONE || ph == PH_ERROR) return;
        if (c) begin
            if (ph <= PH_HEADERS) parse_error();
            else parse_done();
        end else if (ph <= PH_HEADERS) begin
            header_step(b);
        end else begin
            body_step(b);
        end
        if (expected_results.size() > before_n) expected_results[$].last = 1'b1;
    endtask

    // Driver: a request stays on the port until full lets it through.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                predict_request(i_data_byte, i_closed);
                taken_count <= taken_count + 1;
            end
            if (push && full) begin
                // Hold the current request.
            end else if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
                push <= 1'b1;
                i_data_byte <= pending_bytes[0].data;
                i_closed <= pending_bytes[0].closed;
                void'(pending_bytes.pop_front());
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: compares each popped result with the oldest expectation.
    always @(posedge i_clk) begin
        t_expected e;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result kind %0d", o_kind);
                end else begin
                    e = expected_results.pop_front();
                    if (o_kind !== e.kind || o_body_byte !== e.body_byte
                        || o_http_status !== e.http_status || o_last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected kind %0d byte %h status %0d",
                                      " last %0d, got kind %0d byte %h status %0d",
                                      " last %0d"},
                                     e.kind, e.body_byte, e.http_status, e.last,
                                     o_kind, o_body_byte, o_http_status, o_last);
                    end
                end
            end
            // One long hold-off lets the queue fill and stall the sender.
            if (!stall_done && taken_count >= 300) begin
                stall_done <= 1'b1;
                stall_left <= 300;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        t_request r;
        r.data = b;
        r.closed = 1'b0;
        pending_bytes.push_back(r);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic queue_chunk(input int size);
        string s;
        s = $sformatf("%0h", size);
        if ($urandom_range(1)) s = s.toupper();
        if ($urandom_range(3) == 0) s = {"0", s};
        if ($urandom_range(3) == 0) s = {s, ";ext=A\r"};
        queue_text({s, "\r\n"});
        for (int i = 0; i < size; i++) queue_byte(8'($urandom_range(255)));
        queue_byte(8'($urandom_range(255)));
        queue_byte(8'($urandom_range(255)));
    endtask

    task automatic queue_chunks(input int budget);
        int stop_at;
        stop_at = taken_count + pending_bytes.size() + budget;
        while (taken_count + pending_bytes.size() < stop_at) begin
            queue_chunk(($urandom_range(9) == 0) ? $urandom_range(40, 64)
                                                 : $urandom_range(1, 16));
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() > 0 || push || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [MAX_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        body_limit = 64'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_request r;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        push = 1'b0;
        pop = 1'b0;
        i_data_byte = 8'd0;
        i_closed = 1'b0;
        mismatches = 0;
        taken_count = 0;
        stall_left = 0;
        stall_done = 0;
        send_idle = 30;
        recv_idle = 85;
        ph = PH_VERSION;
        foreach (win[i]) win[i] = 8'd0;
        hdr_pos = 0;
        status_val = 0;
        term_cnt = 0;
        enc_seen = 0;
        len_seen = 0;
        chunked = 0;
        kw_idx = 0;
        len_stage = 0;
        decl_len = 0;
        chunk_left = 0;
        body_count = 0;
        body_limit = 64'(MAX_RESET);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_limit({MAX_W{1'b1}});
        // Chunked selection wins over a length header that comes first.
        queue_text("HTTP/1.1  +204 No Content\r\nX-Pad: 7\r\n");
        queue_text("Content-Length: 12\r\ntransfer-ENCODING:  Chunked\r\n\r\n");
        queue_chunk(1);
        queue_chunks(430);
        wait_idle();

        write_limit(MAX_W'({$urandom_range(255), 32'h0}) | 40'h10_0000);
        send_idle = 85;
        recv_idle = 30;
        queue_chunks(430);
        wait_idle();

        write_limit(MAX_RESET);
        send_idle = 0;
        recv_idle = 0;
        queue_chunks(430);
        wait_idle();

        // A limit of one byte rejects the next chunk; the rest is dropped.
        write_limit(40'd1);
        queue_text("a;junk\r\n");
        repeat (6) queue_byte(8'($urandom_range(255)));
        r.data = 8'd0;
        r.closed = 1'b1;
        pending_bytes.push_back(r);
        wait_idle();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* http_response_body_deframer_unit.f */
rtl/rhdu_pkg.sv
rtl/rhdu_front.sv
rtl/rhdu_queue.sv
rtl/rhdu_back.sv
rtl/http_response_body_deframer_unit.sv
tb/sv/tb_top.sv
